/* hw/rtl/assert_macros.svh */
// Assertion helpers, included by the summary statistics unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* hw/rtl/lss_pkg.sv */
package lss_pkg;

	// Widths fixed by the record and summary formats.
	localparam int VAL_W = 32;
	localparam int CNT_OUT_W = 11;
	localparam int THR_W = 43;
	localparam int MAX_RECORDS_DEF = 1024;
	localparam logic [VAL_W-1:0] DURATION_RESET = 32'd65536;

	// floor(m / 5) is (m * RANK_RECIP) >> RANK_RECIP_SHIFT for every m below 2**16.
	localparam logic [15:0] RANK_RECIP = 16'd52429;
	localparam int RANK_RECIP_SHIFT = 18;

	typedef struct packed {
		logic [VAL_W-1:0] arrive_ts;
		logic [VAL_W-1:0] leave_ts;
		logic [VAL_W-1:0] delay_value;
		logic             last_record;
	} rec_t;

	typedef struct packed {
		logic [CNT_OUT_W-1:0] generated_count;
		logic [CNT_OUT_W-1:0] completed_count;
		logic [CNT_OUT_W-1:0] unfinished_count;
		logic [VAL_W-1:0]     mean_delay_completed;
		logic [VAL_W-1:0]     mean_delay_all;
		logic [VAL_W-1:0]     max_delay_completed;
		logic [VAL_W-1:0]     p95_delay_completed;
		logic [THR_W-1:0]     throughput_rate;
		logic [VAL_W-1:0]     mean_system_time;
		logic                 capacity_overflow;
	} summary_t;

	// Per-cycle command to every cell of the sorting chain.
	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctl_t;

endpackage

/* hw/rtl/lss_sort_cell.sv */
module lss_sort_cell
	import lss_pkg::*;
(
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [VAL_W-1:0] x,
	input  logic             occ,
	input  logic             up_keep,
	input  logic [VAL_W-1:0] up_val,
	input  logic [VAL_W-1:0] dn_val,
	output logic [VAL_W-1:0] val,
	output logic             keep
);

	logic [VAL_W-1:0] val_q;

	// The chain is kept in descending order; a cell keeps its value when it
	// already holds something at least as large as the new one.
	assign keep = occ && (val_q >= x);
	assign val = val_q;

	// Insert pushes smaller values one cell down; shift moves values up.
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!keep) begin
				val_q <= up_keep ? x : up_val;
			end
		end else if (ctl.shift) begin
			val_q <= dn_val;
		end
	end

endmodule

/* hw/rtl/lss_divider.sv */
module lss_divider
	import lss_pkg::*;
#(
	parameter int DW = THR_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DW-1:0]    dividend,
	input  logic [VAL_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DW-1:0]    quotient
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    dvd_q;
	logic [VAL_W-1:0] dsr_q;
	logic [VAL_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [VAL_W:0]   trial;
	logic             fits;

	// One restoring step: bring down the next dividend bit and try to subtract.
	assign trial = {rem_q, dvd_q[DW-1]};
	assign fits = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits enter at the bottom of the dividend register.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], fits};
			rem_q <= fits ? VAL_W'(trial - {1'b0, dsr_q}) : VAL_W'(trial);
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = dvd_q;

endmodule

/* hw/rtl/latency_summary_statistics_unit.sv */
// Latency summary statistics over one run of records.
// A record transfer happens at a rising edge with start high and busy low;
// the fields travel in item. While loading, one record is taken every cycle:
// if there is room it is counted, summed and, when complete, inserted into a
// descending chain of sorting cells in the same cycle; else overflow is set.
// The record marked last starts the summary. A shared restoring divider
// (one quotient bit per cycle) works out the three means and the
// throughput in turn. The percentile offset floor(n/20) comes from a
// reciprocal multiply; the cell chain then shifts up floor(n/20) times and
// its head is the 95th percentile. Busy stays high from the last record
// transfer through the divisions, the shifts and the output state.
// The summary is on result from the first cycle with busy low, marked by
// result_valid for a single cycle; a new record may transfer in that cycle.
// The receiver cannot stall it. Loading resumes with the run state cleared.
// cfg_we writes run_duration from cfg_wdata; write it only while idle.
// Reset clears all counts and sets run_duration to 1.0 (Q16.16).
module latency_summary_statistics_unit
	import lss_pkg::*;
#(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  rec_t             item,
	output logic             busy,
	input  logic             cfg_we,
	input  logic [VAL_W-1:0] cfg_wdata,
	output logic             result_valid,
	output summary_t         result
);

	`include "assert_macros.svh"

	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam int SW = VAL_W + CW;
	localparam int DW = (SW > THR_W) ? SW : THR_W;
	localparam int RW = CW + 16;

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_SHIFT = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	localparam logic [1:0] DIV_MEAN_C = 2'd0;
	localparam logic [1:0] DIV_MEAN_A = 2'd1;
	localparam logic [1:0] DIV_MEAN_S = 2'd2;
	localparam logic [1:0] DIV_THR    = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       sel_q;
	logic             wait_q;
	logic [VAL_W-1:0] dur_q;
	logic [CW-1:0]    acc_q;
	logic [CW-1:0]    comp_q;
	logic [SW-1:0]    sum_a_q;
	logic [SW-1:0]    sum_c_q;
	logic [SW-1:0]    sum_s_q;
	logic [VAL_W-1:0] max_q;
	logic             ovf_q;
	logic [CW-1:0]    shift_cnt_q;
	logic [VAL_W-1:0] mean_c_q;
	logic [VAL_W-1:0] mean_a_q;
	logic [VAL_W-1:0] mean_s_q;
	logic [THR_W-1:0] thr_q;
	logic             res_valid_q;
	summary_t         res_q;

	logic             take;
	logic             room;
	logic             is_done;
	cell_ctl_t        ctl;
	logic             div_start;
	logic             div_busy;
	logic             div_done;
	logic [DW-1:0]    div_dvd;
	logic [VAL_W-1:0] div_dsr;
	logic [DW-1:0]    div_quot;
	logic [RW-1:0]    rank_prod;
	logic [CW-1:0]    rank_shift;
	logic [VAL_W-1:0] cell_val [MAX_RECORDS];
	logic             cell_keep [MAX_RECORDS];

	assign take = start && (state_q == ST_LOAD);
	assign room = acc_q < CW'(MAX_RECORDS);
	assign is_done = item.leave_ts <= dur_q;
	assign ctl.ins = take && room && is_done;
	assign ctl.shift = (state_q == ST_SHIFT) && (shift_cnt_q != '0);
	assign busy = state_q != ST_LOAD;

	// Percentile offset floor(n/20), taken as floor(floor(n/4) / 5).
	assign rank_prod = RW'(comp_q >> 2) * RW'(RANK_RECIP);
	assign rank_shift = CW'(rank_prod >> RANK_RECIP_SHIFT);

	// Sorting chain, largest value at the head.
	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		logic             up_keep;
		logic [VAL_W-1:0] up_val;
		logic [VAL_W-1:0] dn_val;
		if (i == 0) begin : g_head
			assign up_keep = 1'b1;
			assign up_val = item.delay_value;
		end else begin : g_body
			assign up_keep = cell_keep[i-1];
			assign up_val = cell_val[i-1];
		end
		if (i == MAX_RECORDS - 1) begin : g_tail
			assign dn_val = cell_val[i];
		end else begin : g_mid
			assign dn_val = cell_val[i+1];
		end
		lss_sort_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.x       (item.delay_value),
			.occ     (CW'(i) < comp_q),
			.up_keep (up_keep),
			.up_val  (up_val),
			.dn_val  (dn_val),
			.val     (cell_val[i]),
			.keep    (cell_keep[i])
		);
	end

	// Operand selection for the shared divider; the last arm is the throughput.
	always_comb begin
		case (sel_q)
			DIV_MEAN_C: begin
				div_dvd = DW'(sum_c_q);
				div_dsr = VAL_W'(comp_q);
			end
			DIV_MEAN_A: begin
				div_dvd = DW'(sum_a_q);
				div_dsr = VAL_W'(acc_q);
			end
			DIV_MEAN_S: begin
				div_dvd = DW'(sum_s_q);
				div_dsr = VAL_W'(comp_q);
			end
			default: begin
				div_dvd = DW'({comp_q, {VAL_W{1'b0}}});
				div_dsr = dur_q;
			end
		endcase
	end

	assign div_start = (state_q == ST_DIV) && !wait_q;

	lss_divider #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Run duration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q <= DURATION_RESET;
		end else if (cfg_we) begin
			dur_q <= cfg_wdata;
		end
	end

	// Run accumulation, summary sequencing and clearing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			sel_q <= DIV_MEAN_C;
			wait_q <= 1'b0;
			acc_q <= '0;
			comp_q <= '0;
			sum_a_q <= '0;
			sum_c_q <= '0;
			sum_s_q <= '0;
			max_q <= '0;
			ovf_q <= 1'b0;
			shift_cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (take) begin
						if (room) begin
							acc_q <= acc_q + 1'b1;
							sum_a_q <= sum_a_q + SW'(item.delay_value);
							if (is_done) begin
								comp_q <= comp_q + 1'b1;
								sum_c_q <= sum_c_q + SW'(item.delay_value);
								if (item.leave_ts > item.arrive_ts) begin
									sum_s_q <= sum_s_q
										+ SW'(item.leave_ts - item.arrive_ts);
								end
								if (item.delay_value > max_q) begin
									max_q <= item.delay_value;
								end
							end
						end else begin
							ovf_q <= 1'b1;
						end
						if (item.last_record) begin
							state_q <= ST_DIV;
							sel_q <= DIV_MEAN_C;
							wait_q <= 1'b0;
						end
					end
				end
				ST_DIV: begin
					if (div_start) begin
						wait_q <= 1'b1;
					end else if (div_done) begin
						wait_q <= 1'b0;
						sel_q <= sel_q + 1'b1;
						if (sel_q == DIV_THR) begin
							shift_cnt_q <= rank_shift;
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					if (shift_cnt_q != '0) begin
						shift_cnt_q <= shift_cnt_q - 1'b1;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					res_valid_q <= 1'b1;
					state_q <= ST_LOAD;
					acc_q <= '0;
					comp_q <= '0;
					sum_a_q <= '0;
					sum_c_q <= '0;
					sum_s_q <= '0;
					max_q <= '0;
					ovf_q <= 1'b0;
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Division results; an empty set gives a zero mean.
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && div_done) begin
			case (sel_q)
				DIV_MEAN_C: mean_c_q <= (comp_q == '0) ? '0 : VAL_W'(div_quot);
				DIV_MEAN_A: mean_a_q <= (acc_q == '0) ? '0 : VAL_W'(div_quot);
				DIV_MEAN_S: mean_s_q <= (comp_q == '0) ? '0 : VAL_W'(div_quot);
				default:    thr_q <= THR_W'(div_quot);
			endcase
		end
	end

	// Summary register, loaded in the output state and held until the next summary.
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) begin
			res_q.generated_count <= CNT_OUT_W'(acc_q);
			res_q.completed_count <= CNT_OUT_W'(comp_q);
			res_q.unfinished_count <= CNT_OUT_W'(acc_q - comp_q);
			res_q.mean_delay_completed <= mean_c_q;
			res_q.mean_delay_all <= mean_a_q;
			res_q.max_delay_completed <= max_q;
			res_q.p95_delay_completed <= (comp_q == '0) ? '0 : cell_val[0];
			res_q.throughput_rate <= thr_q;
			res_q.mean_system_time <= mean_s_q;
			res_q.capacity_overflow <= ovf_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

	`ASSERT_PROP(a_res_idle, clk, arst_n, result_valid |-> !busy)
	`ASSERT_NEVER(a_comp_le_acc, clk, arst_n, comp_q > acc_q)
	`ASSERT_PROP(a_last_busy, clk, arst_n, (take && item.last_record) |=> busy)
	`ASSERT_NEVER(a_div_idle, clk, arst_n, div_busy && (state_q != ST_DIV))

endmodule
